FILE: src/chtab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared constants, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package chtab_pkg;

	localparam int BUCKET_BITS_DEF = 8;
	localparam int NODE_COUNT_DEF  = 256;

	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int HB_W     = 4;

	localparam logic [HB_W-1:0] HASH_BITS_RESET = 4'd8;

	// Fibonacci hashing multiplier, 2^64 divided by the golden ratio.
	localparam logic [63:0] FIB_MUL = 64'h9E37_79B9_7F4A_7C15;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_REMOVE = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_MEMORY = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_HASH,
		S_HEAD_RD,
		S_DISPATCH,
		S_NODE_RD,
		S_NODE_CMP,
		S_UNLINK,
		S_FREE,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    ld_in;
		logic    mul0;
		logic    mul1;
		logic    mul2;
		logic    hash;
		logic    head_rd;
		logic    ins_wr;
		logic    ld_cur;
		logic    adv;
		logic    ld_found;
		logic    unlink;
		logic    free_node;
		logic    clr;
		logic    res_set;
		status_t res_code;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              pool_empty;
		logic              cur_nil;
		logic              key_match;
		logic              clr_last;
		logic              out_free;
	} stat_t;

endpackage
`default_nettype wire

FILE: src/chtab_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chtab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write first in program order; a read of the same address sees old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: src/chtab_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table datapath
// Hash unit, bucket head and node memories, free pool, chain walk pointers
// and the result register.
// ----------------------------------------------------------------------------
module chtab_datapath #(
	parameter int BUCKET_BITS = 8,
	parameter int NODE_COUNT  = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [chtab_pkg::HB_W-1:0]      cfg_wdata,
	input  wire logic [127:0]                    s_tdata,
	input  wire logic [chtab_pkg::MODE_W-1:0]    s_tuser,
	input  wire logic                            m_tready,
	output logic                                 m_tvalid,
	output logic [63:0]                          m_tdata,
	output logic [chtab_pkg::STATUS_W-1:0]       m_tuser,
	input  wire chtab_pkg::cmd_t                 cmd,
	output chtab_pkg::stat_t                     stat
);
	import chtab_pkg::*;

	localparam int LW   = $clog2(NODE_COUNT + 1);
	localparam int NW   = $clog2(NODE_COUNT);
	localparam int NBKT = 1 << BUCKET_BITS;
	localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

	// Control registers.
	logic [HB_W-1:0]        hash_bits_q;
	logic [BUCKET_BITS-1:0] clr_q;
	logic [LW-1:0]          free_q;
	logic [LW-1:0]          fresh_q;
	logic                   out_valid_q;

	// Payload registers.
	logic [KEY_W-1:0]       key_q;
	logic [VAL_W-1:0]       val_q;
	logic [MODE_W-1:0]      mode_q;
	logic [63:0]            plo_q;
	logic [31:0]            hi_q;
	logic [BUCKET_BITS-1:0] bucket_q;
	logic [LW-1:0]          cur_q;
	logic [LW-1:0]          prev_q;
	logic [VAL_W-1:0]       found_q;
	logic [STATUS_W-1:0]    res_q;
	logic [63:0]            out_data_q;
	logic [STATUS_W-1:0]    out_user_q;

	// Memory ports.
	logic                       bkt_we;
	logic [BUCKET_BITS-1:0]     bkt_waddr;
	logic [LW-1:0]              bkt_wdata;
	logic [LW-1:0]              head_rd;
	logic                       nxt_we;
	logic [NW-1:0]              nxt_waddr;
	logic [LW-1:0]              nxt_wdata;
	logic [NW-1:0]              nxt_raddr;
	logic [LW-1:0]              next_rd;
	logic                       dat_we;
	logic [KEY_W+VAL_W-1:0]     dat_rd;

	// Hash unit signals.
	logic [31:0]            mul_a;
	logic [31:0]            mul_b;
	logic [63:0]            mul_p;
	logic [31:0]            top32;
	logic [BUCKET_BITS-1:0] top_bits;
	logic [4:0]             eff;
	logic [4:0]             shamt;

	// Allocation signals.
	logic          use_stack;
	logic          prev_nil;
	logic [LW-1:0] new_node;

	// Shared 32 by 32 multiplier for the mul0, mul1 and mul2 steps; the
	// product's low 64 bits alone matter: the high by high term is dropped.
	assign mul_a = (cmd.mul1) ? key_q[63:32] : key_q[31:0];
	assign mul_b = (cmd.mul2) ? FIB_MUL[63:32] : FIB_MUL[31:0];
	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign top32 = plo_q[63:32] + hi_q;
	assign top_bits = top32[31 -: BUCKET_BITS];

	// Effective hash width, saturated into one to BUCKET_BITS.
	always_comb begin
		eff = {1'b0, hash_bits_q};
		if (eff == 5'd0) begin
			eff = 5'd1;
		end else if (eff > 5'(BUCKET_BITS)) begin
			eff = 5'(BUCKET_BITS);
		end
		shamt = 5'(BUCKET_BITS) - eff;
	end

	// Free pool: a stack of returned nodes in front of never used ones.
	assign use_stack = (free_q != NIL);
	assign new_node  = use_stack ? free_q : fresh_q;
	assign prev_nil  = (prev_q == NIL);

	// Bucket head memory write selection.
	assign bkt_we    = cmd.clr | cmd.ins_wr | (cmd.unlink & prev_nil);
	assign bkt_waddr = cmd.clr ? clr_q : bucket_q;
	assign bkt_wdata = cmd.clr ? NIL : (cmd.ins_wr ? new_node : next_rd);

	// Node link memory write and read selection.
	assign nxt_we = cmd.ins_wr | (cmd.unlink & ~prev_nil) | cmd.free_node;
	always_comb begin
		nxt_waddr = cur_q[NW-1:0];
		nxt_wdata = free_q;
		if (cmd.ins_wr) begin
			nxt_waddr = new_node[NW-1:0];
			nxt_wdata = head_rd;
		end else if (cmd.unlink) begin
			nxt_waddr = prev_q[NW-1:0];
			nxt_wdata = next_rd;
		end
	end
	assign nxt_raddr = cmd.head_rd ? free_q[NW-1:0] : cur_q[NW-1:0];

	assign dat_we = cmd.ins_wr;

	chtab_ram #(.WIDTH(LW), .DEPTH(NBKT)) u_bkt_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wdata),
		.raddr (bucket_q),
		.rdata (head_rd)
	);

	chtab_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (nxt_raddr),
		.rdata (next_rd)
	);

	chtab_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(NODE_COUNT)) u_dat_ram (
		.clk   (clk),
		.we    (dat_we),
		.waddr (new_node[NW-1:0]),
		.wdata ({val_q, key_q}),
		.raddr (cur_q[NW-1:0]),
		.rdata (dat_rd)
	);

	// Control state: register, clearing sweep, free pool and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_bits_q <= HASH_BITS_RESET;
			clr_q       <= '0;
			free_q      <= NIL;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				hash_bits_q <= cfg_wdata;
				clr_q       <= '0;
				free_q      <= NIL;
				fresh_q     <= '0;
			end else begin
				if (cmd.clr) begin
					clr_q <= clr_q + 1'b1;
				end
				if (cmd.ins_wr) begin
					if (use_stack) begin
						free_q <= next_rd;
					end else begin
						fresh_q <= fresh_q + 1'b1;
					end
				end else if (cmd.free_node) begin
					free_q <= cur_q;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: input capture, hash, chain walk and result.
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			key_q   <= s_tdata[63:0];
			val_q   <= s_tdata[127:64];
			mode_q  <= s_tuser;
			found_q <= '0;
		end
		if (cmd.mul0) begin
			plo_q <= mul_p;
		end
		if (cmd.mul1) begin
			hi_q <= mul_p[31:0];
		end
		if (cmd.mul2) begin
			hi_q <= hi_q + mul_p[31:0];
		end
		if (cmd.hash) begin
			bucket_q <= top_bits >> shamt;
		end
		if (cmd.ld_cur) begin
			cur_q  <= head_rd;
			prev_q <= NIL;
		end else if (cmd.adv) begin
			prev_q <= cur_q;
			cur_q  <= next_rd;
		end
		if (cmd.ld_found) begin
			found_q <= dat_rd[KEY_W +: VAL_W];
		end
		if (cmd.res_set) begin
			res_q <= cmd.res_code;
		end
		if (cmd.out_load) begin
			out_data_q <= found_q;
			out_user_q <= res_q;
		end
	end

	// Status toward the controller.
	assign stat.mode       = mode_q;
	assign stat.pool_empty = ~use_stack & (fresh_q == NIL);
	assign stat.cur_nil    = (cur_q == NIL);
	assign stat.key_match  = (dat_rd[KEY_W-1:0] == key_q);
	assign stat.clr_last   = &clr_q;
	assign stat.out_free   = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
`default_nettype wire

FILE: src/chtab_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table controller
// Sequences the clearing sweep, the hash, insert, the chain walk and remove.
// ----------------------------------------------------------------------------
module chtab_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire chtab_pkg::stat_t stat,
	output chtab_pkg::cmd_t       cmd
);
	import chtab_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_code = ST_NOT_FOUND;
		s_tready     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_HASH;
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				state_d  = S_HEAD_RD;
			end
			S_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_DISPATCH;
			end
			S_DISPATCH: begin
				cmd.res_set = 1'b1;
				state_d     = S_FIN;
				unique case (stat.mode)
					MODE_INSERT: begin
						if (stat.pool_empty) begin
							cmd.res_code = ST_NO_MEMORY;
						end else begin
							cmd.ins_wr   = 1'b1;
							cmd.res_code = ST_OK;
						end
					end
					MODE_LOOKUP, MODE_REMOVE: begin
						cmd.res_set = 1'b0;
						cmd.ld_cur  = 1'b1;
						state_d     = S_NODE_RD;
					end
					default: begin
						cmd.res_code = ST_NOT_FOUND;
					end
				endcase
			end
			S_NODE_RD: begin
				if (stat.cur_nil) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_NOT_FOUND;
					state_d      = S_FIN;
				end else begin
					state_d = S_NODE_CMP;
				end
			end
			S_NODE_CMP: begin
				if (stat.key_match) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					if (stat.mode == MODE_LOOKUP) begin
						cmd.ld_found = 1'b1;
						state_d      = S_FIN;
					end else begin
						state_d = S_UNLINK;
					end
				end else begin
					cmd.adv = 1'b1;
					state_d = S_NODE_RD;
				end
			end
			S_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d    = S_FREE;
			end
			S_FREE: begin
				cmd.free_node = 1'b1;
				state_d       = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		// A register write empties the table by a new clearing sweep.
		if (cfg_we) begin
			state_d = S_CLEAR;
		end
	end

endmodule
`default_nettype wire

FILE: src/chained_hash_table_core.sv
// Insert: an accepted beat passes S_MUL0, S_MUL1, S_MUL2, S_HASH, S_HEAD_RD,
// S_DISPATCH and S_FIN. Lookup and remove walk the chain through S_NODE_RD
// and S_NODE_CMP, node by node; remove then passes S_UNLINK and S_FREE.
// One item is in flight at a time; the hash uses one multiplier.
// After reset and after every hash_bits write a clearing sweep empties
// all 2^BUCKET_BITS bucket heads; no input beat is taken then.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table core
// Key-value map with Fibonacci hashing and per-bucket chains of pool nodes.
// ----------------------------------------------------------------------------
module chained_hash_table_core #(
	parameter int BUCKET_BITS = chtab_pkg::BUCKET_BITS_DEF,
	parameter int NODE_COUNT  = chtab_pkg::NODE_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [chtab_pkg::HB_W-1:0]    cfg_wdata,  // hash_bits
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [127:0]                  s_tdata,    // key, value
	input  wire logic [chtab_pkg::MODE_W-1:0]  s_tuser,    // mode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [63:0]                        m_tdata,    // found_value
	output logic [chtab_pkg::STATUS_W-1:0]     m_tuser     // status
);
	import chtab_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	chtab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	chtab_datapath #(
		.BUCKET_BITS (BUCKET_BITS),
		.NODE_COUNT  (NODE_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire

FILE: src/chtab_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chained hash table checker
// Port-level checks on the result stream and the input handshake.
// ----------------------------------------------------------------------------
module chtab_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import chtab_pkg::*;

	// A result beat that is not taken stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// The unused status code never appears.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NO_MEMORY ||
			m_tuser == ST_NOT_FOUND))
		else $error("result carries an unused status code");

	// A failed operation returns a zero value.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == 64'd0)
		else $error("failed operation returned a nonzero value");

	// One operation at a time: no input beat in the cycle after one is taken.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on two consecutive cycles");

endmodule

bind chained_hash_table_core chtab_checker u_chtab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash table core testbench
// Drives insert, lookup and remove beats with random gaps and back-pressure.
// A predictor in the bench keeps its own bucket chains and free pool.
// Every result beat is checked against the oldest expected result. The run
// covers several hash widths, pool exhaustion, duplicate keys and the unused
// mode.
// ----------------------------------------------------------------------------
module tb_top;
	import chtab_pkg::*;

	localparam int BKT_BITS   = BUCKET_BITS_DEF;
	localparam int NODES      = NODE_COUNT_DEF;
	localparam int NULL_LINK  = NODES;
	localparam int IDLE_LIMIT = 5000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [HB_W-1:0] HB_ZERO = 4'd0;
	localparam logic [HB_W-1:0] HB_ONE  = 4'd1;
	localparam logic [HB_W-1:0] HB_FOUR = 4'd4;
	localparam logic [HB_W-1:0] HB_MAX  = 4'd15;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [63:0]         value;
	} answer_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [HB_W-1:0]     cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [127:0]        s_tdata;    // key, value
	logic [MODE_W-1:0]   s_tuser;    // mode
	logic                m_tvalid;
	logic                m_tready;
	logic [63:0]         m_tdata;    // found_value
	logic [STATUS_W-1:0] m_tuser;    // status

	chained_hash_table_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Predicted table contents.
	int          head_of[1 << BKT_BITS];
	logic [63:0] key_of[NODES];
	logic [63:0] val_of[NODES];
	int          next_of[NODES];
	int          free_top;
	logic [HB_W-1:0] hash_width;

	answer_t     answers_due[$];
	logic [63:0] key_pool[32];
	int          errors;
	int          hold_long;
	int          idle_cycles;

	// Clock generation.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void clear_table();
		for (int i = 0; i < (1 << BKT_BITS); i++) head_of[i] = NULL_LINK;
		for (int i = 0; i < NODES; i++) begin
			key_of[i] = '0;
			val_of[i] = '0;
			next_of[i] = i + 1;
		end
		free_top = 0;
	endfunction

	function automatic int bucket_index(logic [63:0] key);
		logic [63:0] prod;
		int          eff;
		prod = key * FIB_MUL;
		eff = hash_width;
		if (eff < 1) eff = 1;
		if (eff > BKT_BITS) eff = BKT_BITS;
		return int'(prod >> (64 - eff));
	endfunction

	// Applies one operation to the predicted table and returns its answer.
	function automatic answer_t apply_op(logic [MODE_W-1:0] mode, logic [63:0] key,
			logic [63:0] value);
		answer_t ans;
		int      b;
		int      prev;
		int      cur;
		int      steps;
		b = bucket_index(key);
		ans.status = ST_NOT_FOUND;
		ans.value = '0;
		if (mode == MODE_INSERT) begin
			if (free_top >= NODES) begin
				ans.status = ST_NO_MEMORY;
			end else begin
				cur = free_top;
				free_top = next_of[cur];
				key_of[cur] = key;
				val_of[cur] = value;
				next_of[cur] = head_of[b];
				head_of[b] = cur;
				ans.status = ST_OK;
			end
		end else if (mode == MODE_LOOKUP || mode == MODE_REMOVE) begin
			prev = NULL_LINK;
			cur = head_of[b];
			steps = 0;
			while (cur < NODES && steps < NODES && key_of[cur] != key) begin
				prev = cur;
				cur = next_of[cur];
				steps++;
			end
			if (cur < NODES && steps < NODES) begin
				ans.status = ST_OK;
				if (mode == MODE_LOOKUP) begin
					ans.value = val_of[cur];
				end else begin
					if (prev >= NODES) head_of[b] = next_of[cur];
					else next_of[prev] = next_of[cur];
					next_of[cur] = free_top;
					free_top = cur;
				end
			end
		end
		return ans;
	endfunction

	// Predict on every accepted input beat.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			answers_due.push_back(apply_op(s_tuser, s_tdata[63:0], s_tdata[127:64]));
	end

	// Check every accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result beat status=%0d value=%h",
					$time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (m_tuser !== want.status || m_tdata !== want.value) begin
					$display("%0t: mismatch expected status=%0d value=%h, actual status=%0d value=%h",
						$time, want.status, want.value, m_tuser, m_tdata);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls, mostly short, a few long, plus a forced hold-off.
	always @(negedge clk) begin
		int stall;
		if (hold_long > 0) begin
			hold_long--;
			m_tready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 1'b0;
		end else if ($urandom_range(99) < 15) begin
			stall = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic send_item(logic [MODE_W-1:0] mode, logic [63:0] key, logic [63:0] value);
		int gap;
		gap = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2);
		if ($urandom_range(3) == 0) gap = 0;
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {value, key};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		@(negedge clk) s_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_hash_bits(logic [HB_W-1:0] hb);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= hb;
		@(negedge clk) cfg_we <= 1'b0;
		hash_width = hb;
		clear_table();
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_key();
		if ($urandom_range(4) == 0) return rand64();
		return key_pool[$urandom_range(31)];
	endfunction

	// Random mix over a pool of keys so that hits and misses both happen.
	task automatic run_random(int count, int insert_pct);
		int          r;
		logic [MODE_W-1:0] mode;
		foreach (key_pool[i]) key_pool[i] = rand64();
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 3) mode = MODE_UNUSED;
			else if (r < insert_pct) mode = MODE_INSERT;
			else if (r < insert_pct + (100 - insert_pct) / 2) mode = MODE_LOOKUP;
			else mode = MODE_REMOVE;
			send_item(mode, pick_key(), rand64());
		end
	endtask

	task automatic test_directed();
		logic [63:0] ones;
		ones = '1;
		send_item(MODE_LOOKUP, 64'd0, ones);
		send_item(MODE_REMOVE, ones, 64'd0);
		send_item(MODE_INSERT, 64'd0, ones);
		send_item(MODE_INSERT, ones, 64'd0);
		send_item(MODE_LOOKUP, 64'd0, 64'd0);
		send_item(MODE_LOOKUP, ones, ones);
		// A duplicate key shadows the older entry until it is removed.
		send_item(MODE_INSERT, 64'd0, 64'h5555_5555_5555_5555);
		send_item(MODE_LOOKUP, 64'd0, 64'd0);
		send_item(MODE_REMOVE, 64'd0, 64'd0);
		send_item(MODE_LOOKUP, 64'd0, 64'd0);
		send_item(MODE_REMOVE, 64'd0, 64'd0);
		send_item(MODE_REMOVE, 64'd0, 64'd0);
		send_item(MODE_UNUSED, ones, ones);
		send_item(MODE_LOOKUP, ones, 64'd0);
		send_item(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF);
		send_item(MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0);
	endtask

	// Small table with long chains; the pool runs dry, then some nodes are freed.
	task automatic test_pool_exhaustion();
		logic [63:0] keys[NODES];
		write_hash_bits(HB_ONE);
		for (int i = 0; i < NODES; i++) begin
			keys[i] = rand64();
			send_item(MODE_INSERT, keys[i], rand64());
		end
		send_item(MODE_INSERT, rand64(), rand64());
		send_item(MODE_INSERT, keys[0], rand64());
		for (int i = 0; i < 20; i++) send_item(MODE_LOOKUP, keys[$urandom_range(NODES - 1)], 0);
		send_item(MODE_LOOKUP, keys[0], 0);
		for (int i = 0; i < 20; i++) send_item(MODE_REMOVE, keys[$urandom_range(NODES - 1)], 0);
		for (int i = 0; i < 10; i++) send_item(MODE_INSERT, rand64(), rand64());
	endtask

	// Receiver holds off for a long stretch while input beats keep coming.
	task automatic test_backpressure();
		hold_long = 300;
		run_random(12, 50);
	endtask

	task automatic test_hash_widths();
		write_hash_bits(HB_ZERO);
		run_random(200, 40);
		write_hash_bits(HB_MAX);
		run_random(200, 45);
		write_hash_bits(HB_FOUR);
		run_random(250, 60);
		wait_drained();
		write_hash_bits(HASH_BITS_RESET);
		run_random(170, 55);
	endtask

	initial begin
		errors = 0;
		hold_long = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_INSERT;
		m_tready = 1'b0;
		hash_width = HASH_BITS_RESET;
		clear_table();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_directed();
		run_random(150, 50);
		test_backpressure();
		test_pool_exhaustion();
		test_hash_widths();

		wait_drained();
		repeat (600) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/chtab_pkg.sv
src/chtab_ram.sv
src/chtab_datapath.sv
src/chtab_ctrl.sv
src/chained_hash_table_core.sv
src/chtab_checker.sv
tb/tb_top.sv
